@@ rtl/ckre_pkg.sv @@
package ckre_pkg;

  // Geometry
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  // Register widths
  localparam int unsigned KEY_W   = 24;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CFG_W   = KEY_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Result field widths
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned FIRST_W = 12;
  localparam int unsigned STOP_W  = 13;

  // Key window constants
  localparam logic [KEY_W-1:0] KEY_WHITE   = 24'hFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_BLACK   = 24'h00_0000;
  localparam logic [7:0]       WHITE_LO    = 8'hEF;
  localparam logic [7:0]       BLACK_HI    = 8'h10;
  localparam logic [7:0]       WIN_HALF    = 8'h11;
  localparam logic [7:0]       CHAN_MAX    = 8'hFF;

  // Reset values of the registers
  localparam logic [KEY_W-1:0] KEY_COLOR_RST    = KEY_BLACK;
  localparam logic             RUN_POLARITY_RST = 1'b1;
  localparam logic [DIM_W-1:0] FRAME_DIM_RST    = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COLOR    = 2'd0,
    REG_RUN_POLARITY = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // One channel against its window around the key channel.
  function automatic logic chan_in_window(input logic [7:0] pix,
                                          input logic [7:0] key_ch,
                                          input logic       key_white,
                                          input logic       key_black);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = '0;
    hi = CHAN_MAX;
    if (key_white) begin
      lo = WHITE_LO;
      hi = CHAN_MAX;
    end else if (key_black) begin
      lo = '0;
      hi = BLACK_HI;
    end else begin
      lo = (key_ch >= WIN_HALF) ? key_ch - WIN_HALF : 8'd0;
      hi = (key_ch > CHAN_MAX - WIN_HALF) ? CHAN_MAX : key_ch + WIN_HALF;
    end
    return (pix >= lo) && (pix <= hi);
  endfunction

endpackage

@@ rtl/color_key_run_extractor_core.sv @@
// Color-key run extractor. Takes RGB pixels in raster order, one item per
// clock when not stalled, and compares each against a window around key_color
// (white key: 0xEF..0xFF per channel, black key: 0..0x10, other keys: +/-0x11
// clamped). When a horizontal run of selected pixels ends (at an unselected
// pixel or at the end of a row) one span item is emitted: row, first column
// and exclusive stop column. run_polarity=1 selects non-key pixels, 0 selects
// key pixels. Throughput is one pixel per cycle while the result side does not
// stall; a pixel moves through the input register, then the result register.
// The limit is the single window compare and run update between those two
// registers; a stalled result register holds the pixel waiting in the input
// register. Frame width and height are clamped to 1..MAX_DIM. Configuration
// is written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
module color_key_run_extractor_core #(
  parameter int unsigned MAX_DIM = ckre_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ckre_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ckre_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     pix_red_i,
  input  logic [7:0]                     pix_green_i,
  input  logic [7:0]                     pix_blue_i,
  // span items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ckre_pkg::ROW_W-1:0]     span_row_o,
  output logic [ckre_pkg::FIRST_W-1:0]   span_first_o,
  output logic [ckre_pkg::STOP_W-1:0]    span_stop_o
);
  import ckre_pkg::*;

  // Counter width holds 0..MAX_DIM-1; dimension width holds 1..MAX_DIM.
  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] key_color_q;
  logic             run_polarity_q;
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color_q    <= KEY_COLOR_RST;
      run_polarity_q <= RUN_POLARITY_RST;
      frame_width_q  <= FRAME_DIM_RST;
      frame_height_q <= FRAME_DIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_COLOR:    key_color_q    <= cfg_data_i[KEY_W-1:0];
        REG_RUN_POLARITY: run_polarity_q <= cfg_data_i[0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
      endcase
    end
  end

  // Saturate a dimension register to 1..MAX_DIM.
  function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [DW-1:0] eff_width;
  logic [DW-1:0] eff_height;

  assign eff_width  = eff_dim(frame_width_q);
  assign eff_height = eff_dim(frame_height_q);

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  pixel_t s1_pix_q;
  logic   s1_valid_q, s1_valid_d;
  logic   in_accept;
  logic   advance;

  // Advance the held pixel whenever the result register is free or draining.
  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q <= '{blue: pix_blue_i, green: pix_green_i, red: pix_red_i};
    end
  end

  // ---------------------------------------------------------------------
  // Window compare and run tracking
  // ---------------------------------------------------------------------
  logic is_key;

  ckre_key_match u_key_match (
    .pix_i    (s1_pix_q),
    .key_i    (key_color_q),
    .is_key_o (is_key)
  );

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic          in_run_q, in_run_d;
  logic [CW-1:0] run_begin_q, run_begin_d;

  logic          sel;
  logic          last_col;
  logic          last_row;
  logic [DW-1:0] col_next;
  logic [DW-1:0] row_next;
  logic          emit;
  logic [CW-1:0] first_col;
  logic [DW-1:0] stop_col;

  assign col_next = DW'(col_q) + DW'(1);
  assign row_next = DW'(row_q) + DW'(1);
  // A column at or past the width (geometry changed mid-frame) ends the row too.
  assign last_col = (col_next >= eff_width);
  assign last_row = (row_next >= eff_height);
  assign sel      = run_polarity_q ? !is_key : is_key;

  always_comb begin
    emit        = 1'b0;
    first_col   = run_begin_q;
    stop_col    = DW'(col_q);
    run_begin_d = run_begin_q;
    if (sel) begin
      // Open a run on the first selected pixel; close it at the row end.
      if (!in_run_q) begin
        first_col   = col_q;
        run_begin_d = col_q;
      end
      emit     = last_col;
      stop_col = col_next;
    end else begin
      emit = in_run_q;
    end
  end

  // A run stays open only on a selected pixel that is not the last of the row.
  assign in_run_d = sel && !last_col;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_next[CW-1:0];
    end else begin
      col_d = col_next[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      in_run_q    <= 1'b0;
      run_begin_q <= '0;
    end else if (advance) begin
      col_q       <= col_d;
      row_q       <= row_d;
      in_run_q    <= in_run_d;
      run_begin_q <= run_begin_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                 out_valid_q, out_valid_d;
  logic [ROW_W-1:0]     span_row_q;
  logic [FIRST_W-1:0]   span_first_q;
  logic [STOP_W-1:0]    span_stop_q;

  // Load on advance; otherwise hold while stalled and drop once taken.
  assign out_valid_d = advance ? emit : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Mask result fields to their port widths.
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      span_row_q   <= ROW_W'(row_q);
      span_first_q <= FIRST_W'(first_col);
      span_stop_q  <= STOP_W'(stop_col);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_row_o   = span_row_q;
  assign span_first_o = span_first_q;
  assign span_stop_o  = span_stop_q;

endmodule

@@ rtl/ckre_key_match.sv @@
module ckre_key_match (
  input  ckre_pkg::pixel_t           pix_i,
  input  logic [ckre_pkg::KEY_W-1:0] key_i,
  output logic                       is_key_o
);
  import ckre_pkg::*;

  logic key_white;
  logic key_black;

  assign key_white = (key_i == KEY_WHITE);
  assign key_black = (key_i == KEY_BLACK);

  // A pixel is key only when all three channels sit inside their windows.
  assign is_key_o = chan_in_window(pix_i.red,   key_i[7:0],   key_white, key_black)
                 && chan_in_window(pix_i.green, key_i[15:8],  key_white, key_black)
                 && chan_in_window(pix_i.blue,  key_i[23:16], key_white, key_black);

endmodule

@@ rtl/ckre_checker.sv @@
module ckre_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ckre_pkg::ROW_W-1:0]     span_row_o,
  input logic [ckre_pkg::FIRST_W-1:0]   span_first_o,
  input logic [ckre_pkg::STOP_W-1:0]    span_stop_o
);

  // A new span appears only after a taken pixel has passed the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("span item without a pixel item two cycles earlier");

  // Input back-pressure comes only from a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side is free");

  // A span is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, span_first_o} < span_stop_o))
    else $error("span stop not past span first");

  // A stalled span holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(span_row_o) && $stable(span_first_o)
       && $stable(span_stop_o)))
    else $error("stalled span item changed");

endmodule

bind color_key_run_extractor_core ckre_checker u_ckre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .span_row_o   (span_row_o),
  .span_first_o (span_first_o),
  .span_stop_o  (span_stop_o)
);

@@ sim/color_key_run_extractor_core_tb.sv @@
`timescale 1ns / 100ps

module color_key_run_extractor_core_tb;
  import ckre_pkg::*;

  localparam int unsigned MAX_DIM      = MAX_DIM_DEFAULT;
  localparam int unsigned RESET_CYCLES = 11;
  // Two register stages between pixel and span; leave some margin on top.
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned HOLD_LEN     = 40;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_TX,
    IDLE_RX,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [FIRST_W-1:0] first;
    logic [STOP_W-1:0]  stop;
  } span_t;

  // Predicts the spans of the pixel stream and holds the spans still owed.
  class span_scoreboard;
    logic [KEY_W-1:0] key_color;
    bit               polarity;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      run_start;
    bit               run_open;
    span_t            owed_q[$];
    int unsigned      errors;

    function new();
      key_color  = KEY_COLOR_RST;
      polarity   = RUN_POLARITY_RST;
      width_reg  = FRAME_DIM_RST;
      height_reg = FRAME_DIM_RST;
      col_cnt    = 0;
      row_cnt    = 0;
      run_start  = 0;
      run_open   = 0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KEY_COLOR:    key_color  = data;
        REG_RUN_POLARITY: polarity   = data[0];
        REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function bit chan_hit(logic [7:0] pix, logic [7:0] kc);
      int lo;
      int hi;
      int k;
      k = kc;
      if (key_color == KEY_WHITE) begin
        lo = 'hEF;
        hi = 'hFF;
      end else if (key_color == KEY_BLACK) begin
        lo = 0;
        hi = 'h10;
      end else begin
        lo = (k >= 'h11) ? k - 'h11 : 0;
        hi = (k + 'h11 > 'hFF) ? 'hFF : k + 'h11;
      end
      return (int'(pix) >= lo) && (int'(pix) <= hi);
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned stop_col;
      bit          last_col;
      bit          is_key;
      bit          sel;
      bit          emit;
      span_t       s;
      w        = eff_dim(width_reg);
      h        = eff_dim(height_reg);
      last_col = (col_cnt + 1 >= w);
      is_key   = chan_hit(r, key_color[7:0]) && chan_hit(g, key_color[15:8])
                 && chan_hit(b, key_color[23:16]);
      sel      = polarity ? !is_key : is_key;
      emit     = 0;
      stop_col = 0;
      if (sel) begin
        if (!run_open) begin
          run_open  = 1;
          run_start = col_cnt;
        end
        if (last_col) begin
          stop_col = col_cnt + 1;
          emit     = 1;
        end
      end else if (run_open) begin
        stop_col = col_cnt;
        emit     = 1;
      end
      if (emit) begin
        s.row    = row_cnt[ROW_W-1:0];
        s.first  = run_start[FIRST_W-1:0];
        s.stop   = stop_col[STOP_W-1:0];
        owed_q.push_back(s);
        run_open = 0;
      end
      // End of row closes everything and steps the row, wrapping at height.
      if (last_col) begin
        col_cnt  = 0;
        run_open = 0;
        row_cnt  = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
    endfunction

    function void check_span(span_t got);
      span_t exp_s;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected span: expected none, got row %0d first %0d stop %0d",
                 $time, got.row, got.first, got.stop);
        errors++;
        return;
      end
      exp_s = owed_q.pop_front();
      if (got.row !== exp_s.row) begin
        $display("%0t: span_row mismatch: expected %0d, got %0d", $time, exp_s.row, got.row);
        errors++;
      end
      if (got.first !== exp_s.first) begin
        $display("%0t: span_first mismatch: expected %0d, got %0d",
                 $time, exp_s.first, got.first);
        errors++;
      end
      if (got.stop !== exp_s.stop) begin
        $display("%0t: span_stop mismatch: expected %0d, got %0d",
                 $time, exp_s.stop, got.stop);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           pix_red_i;
  logic [7:0]           pix_green_i;
  logic [7:0]           pix_blue_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ROW_W-1:0]     span_row_o;
  logic [FIRST_W-1:0]   span_first_o;
  logic [STOP_W-1:0]    span_stop_o;

  span_scoreboard sb;
  int unsigned    tx_pct   = 0;
  int unsigned    rx_pct   = 0;
  int unsigned    hold_seq = 0;

  wire pix_fire  = in_valid_i && !in_stall_o;
  wire span_fire = out_valid_o && !out_stall_i;

  color_key_run_extractor_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pix_red_i    (pix_red_i),
    .pix_green_i  (pix_green_i),
    .pix_blue_i   (pix_blue_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .span_row_o   (span_row_o),
    .span_first_o (span_first_o),
    .span_stop_o  (span_stop_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stall at the configured rate, or a long hold-off
  // whenever the stimulus bumps hold_seq.
  always @(negedge clk_i) begin : span_sink
    int unsigned seen_seq;
    int unsigned hold_left;
    if (hold_seq != seen_seq) begin
      seen_seq  = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_pct);
    end
  end

  // Check spans before noting the pixel of the same edge, so the order of
  // the two never depends on the scheduler.
  always @(posedge clk_i) begin : monitor
    span_t got;
    if (rst_ni) begin
      if (span_fire) begin
        got.row   = span_row_o;
        got.first = span_first_o;
        got.stop  = span_stop_o;
        sb.check_span(got);
      end
      if (pix_fire) sb.note_pixel(pix_red_i, pix_green_i, pix_blue_i);
    end
  end

  // End the run when nothing moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (pix_fire || span_fire) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Offer one pixel: idle first at the sender's rate, then hold the item
  // until it is taken. Called and returns at a falling edge.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pix_red_i   <= r;
    pix_green_i <= g;
    pix_blue_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed span has come, then settle.
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Write all four registers once the block has gone quiet.
  task automatic reconfigure(input logic [CFG_W-1:0] key, input logic [CFG_W-1:0] pol,
                             input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain(SETTLE);
    cfg_write(REG_KEY_COLOR, key);
    cfg_write(REG_RUN_POLARITY, pol);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin tx_pct = 0;  rx_pct = 0;  end
      IDLE_TX:   begin tx_pct = 45; rx_pct = 0;  end
      IDLE_RX:   begin tx_pct = 0;  rx_pct = 45; end
      IDLE_BOTH: begin tx_pct = 21; rx_pct = 21; end
      default:   begin tx_pct = 0;  rx_pct = 0;  end
    endcase
  endtask

  // A channel near the key: within 19 of the key channel, just past its window.
  function automatic logic [7:0] near_chan(input logic [7:0] kc);
    int v;
    v = int'(kc) + int'($urandom_range(38)) - 19;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Key channel close to the clamp limits of the window.
  function automatic logic [7:0] rim_chan();
    if ($urandom_range(1)) return 8'($urandom_range(8'h16));
    return 8'($urandom_range(8'hFF, 8'hE9));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return KEY_BLACK;
      1:       return KEY_WHITE;
      2:       return {rim_chan(), rim_chan(), rim_chan()};
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Width or height with junk in the unused upper bits of the write data.
  function automatic logic [CFG_W-1:0] dim_word(input int unsigned lo, input int unsigned hi);
    logic [CFG_W-1:0] word;
    word             = CFG_W'($urandom);
    word[DIM_W-1:0]  = DIM_W'($urandom_range(hi, lo));
    return word;
  endfunction

  task automatic send_random(input logic [KEY_W-1:0] key);
    if ($urandom_range(1)) begin
      send_pixel(near_chan(key[7:0]), near_chan(key[15:8]), near_chan(key[23:16]));
    end else begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      sent;
    int unsigned      count;
    int unsigned      sel;
    logic [CFG_W-1:0] w_word;
    logic [CFG_W-1:0] h_word;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_KEY_COLOR;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pix_red_i   = '0;
    pix_green_i = '0;
    pix_blue_i  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: black key, non-key runs, 4096 x 4096. Hit the black
    // window edges and close a run on a key pixel.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h10, 8'h10, 8'h10);
    send_pixel(8'h11, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h10, 8'h10);

    // Shrink the width below the current column: the next pixel ends the
    // row. White key, key runs, two rows so the row count wraps.
    reconfigure(KEY_WHITE, 24'd0, 24'd3, 24'd2);
    send_pixel(8'hEF, 8'hEF, 8'hEF);
    send_pixel(8'hEE, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hF0, 8'hEF);

    // Plain key with clamped windows; zero width and zero height saturate
    // to one, so every pixel is a whole frame.
    reconfigure(24'hF5_80_05, 24'd1, 24'd0, 24'd0);
    send_pixel(8'h16, 8'h91, 8'hE4);
    send_pixel(8'h17, 8'h80, 8'hF5);
    send_pixel(8'h00, 8'h6F, 8'hFF);
    send_pixel(8'h05, 8'h6E, 8'hF5);

    // Oversized width saturates to the maximum. Walk both window edges and
    // leave a run open for the next settings to pick up.
    reconfigure(24'h12_34_56, 24'd0, 24'h1FFF, 24'd8191);
    send_pixel(8'h56, 8'h34, 8'h12);
    send_pixel(8'h45, 8'h23, 8'h01);
    send_pixel(8'h67, 8'h45, 8'h23);
    send_pixel(8'h68, 8'h34, 8'h12);
    send_pixel(8'h56, 8'h34, 8'h12);

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // Maximum width; the run state carries over.
        reconfigure(pick_key(), CFG_W'($urandom_range(1)), 24'd4096, dim_word(1, 6));
        set_idling(IDLE_NONE);
        count = $urandom_range(40, 20);
        repeat (count) send_random(sb.key_color);
        sent += count;
      end else if (phase == 5) begin
        // One pixel per row with the height saturated to the maximum.
        reconfigure(pick_key(), CFG_W'($urandom_range(1)), 24'd1, 24'h1FFF);
        set_idling(IDLE_NONE);
        count = $urandom_range(40, 20);
        repeat (count) send_random(sb.key_color);
        sent += count;
      end else begin
        sel = $urandom_range(9);
        if (sel == 0) w_word = dim_word(0, 0);
        else if (sel == 1) w_word = dim_word(MAX_DIM + 1, 8191);
        else w_word = dim_word(1, 10);
        sel = $urandom_range(9);
        if (sel == 0) h_word = dim_word(0, 0);
        else if (sel == 1) h_word = dim_word(MAX_DIM + 1, 8191);
        else h_word = dim_word(1, 5);
        reconfigure(pick_key(), CFG_W'($urandom), w_word, h_word);
        // Keep the sender busy during the first receiver hold-off, so the block
        // fills and pushes back on its input.
        set_idling((phase == 3) ? IDLE_NONE : idle_mode_e'(phase % 4));
        count = $urandom_range(60, 30);
        for (int unsigned i = 0; i < count; i++) begin
          if (phase % 4 == 3 && i == 5) hold_seq <= hold_seq + 1;
          if (phase % 7 == 6 && i == count / 2) drain(0);
          send_random(sb.key_color);
        end
        sent += count;
      end
      phase++;
    end

    drain(SETTLE);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ color_key_run_extractor_core.f @@
rtl/ckre_pkg.sv
rtl/ckre_key_match.sv
rtl/color_key_run_extractor_core.sv
rtl/ckre_checker.sv
sim/color_key_run_extractor_core_tb.sv
